FILE: rtl/core/dias_pkg.sv
// Shared constants and helper functions for the dihedral angle sine pipeline.
// No dependencies.
package dias_pkg;

	localparam int NRM_W = 67;          // exact face normal component width
	localparam int EDG_W = 33;          // exact edge component width
	localparam int SQRT_W = 62;         // default radicand width of the root unit
	localparam int CORDIC_STEPS = 30;
	localparam logic [30:0] ANGLE_MAX = 31'd843314857;   // pi/2 in Q2.29
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	// bit length of one byte, 0..8
	function automatic logic [3:0] bitlen8(input logic [7:0] x);
		logic [3:0] n;
		n = 4'd0;
		for (int b = 0; b < 8; b++) begin
			if (x[b]) n = 4'(b + 1);
		end
		return n;
	endfunction

	// arctan(2^-i) in Q2.29, round to nearest
	function automatic logic [30:0] atan_q29(input int i);
		logic [30:0] v;
		case (i)
			0: v = 31'd421657428;
			1: v = 31'd248918915;
			2: v = 31'd131521918;
			3: v = 31'd66762579;
			4: v = 31'd33510843;
			5: v = 31'd16771758;
			6: v = 31'd8387925;
			7: v = 31'd4194219;
			8: v = 31'd2097141;
			9: v = 31'd1048575;
			default: v = 31'd1 << (29 - i);
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/core/dias_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on dias_pkg.
module dias_isqrt #(
	parameter int IW = dias_pkg::SQRT_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [IW-1:0]     radicand,
	output logic              out_valid,
	output logic [IW/2-1:0]   root
);
	localparam int N = IW / 2;
	localparam int RW = IW + 1;

	logic [RW-1:0] v_s [1:N];
	logic [RW-1:0] r_s [1:N];
	logic          vld_s [1:N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (IW - 2 - 2 * k);
		logic [RW-1:0] vin, rin, trial;
		logic          vldin;
		if (k == 0) begin : g_first
			assign vin = RW'(radicand);
			assign rin = '0;
			assign vldin = in_valid;
		end else begin : g_next
			assign vin = v_s[k];
			assign rin = r_s[k];
			assign vldin = vld_s[k];
		end
		assign trial = rin + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else vld_s[k+1] <= vldin;
		end

		always_ff @(posedge clk) begin
			if (vin >= trial) begin
				v_s[k+1] <= vin - trial;
				r_s[k+1] <= (rin >> 1) + BIT;
			end else begin
				v_s[k+1] <= vin;
				r_s[k+1] <= rin >> 1;
			end
		end
	end

	assign out_valid = vld_s[N];
	assign root = r_s[N][N-1:0];
endmodule

FILE: rtl/core/dias_unit.sv
// Scales a signed 3-vector to a Q1.30 unit vector: normalize, root, divide.
// Depends on dias_pkg and dias_isqrt.
module dias_unit #(
	parameter int VW = dias_pkg::NRM_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [VW-1:0] vec [3],
	output logic                 out_valid,
	output logic signed [31:0]   unit [3],
	output logic                 zero
);
	localparam int NCH = (VW + 7) / 8;
	localparam int CW = NCH * 8;
	localparam int LBW = $clog2(VW + 1);
	localparam int SQL = 31;            // side delay matching the root unit for a 62-bit radicand
	localparam int DIVN = 31;           // quotient bits

	typedef struct packed {
		logic [2:0][29:0] r;
		logic [2:0]       neg;
		logic             zero;
	} side_t;

	logic            vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic [VW-1:0]   mag_s1 [3], mag_s2 [3], mag_s3 [3], mag_s4 [3];
	logic [2:0]      neg_s1, neg_s2, neg_s3, neg_s4;
	logic [VW-1:0]   or_s2;
	logic [NCH-1:0]  nz_s3;
	logic [3:0]      lbc_s3 [NCH];
	logic [LBW-1:0]  lb_s4, lb_c;
	logic [CW-1:0]   or_pad;
	side_t           side_s5, side_s6, side_s7;
	logic [59:0]     sq_s6 [3];
	logic [61:0]     sum_s7;
	logic            sq_vld;
	logic [30:0]     len_w;
	side_t           side_d [SQL];
	logic [2:0][60:0] num_s8;
	logic [30:0]     len_s8;
	logic [2:0]      negf_s8;
	logic            zero_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= in_valid; vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6; vld_s8 <= sq_vld;
		end
	end

	assign or_pad = CW'(or_s2);

	always_comb begin
		lb_c = '0;
		for (int c = 0; c < NCH; c++) begin
			if (nz_s3[c]) lb_c = LBW'(c * 8) + LBW'(lbc_s3[c]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= vec[i][VW-1];
			mag_s1[i] <= vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]);
		end
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
		or_s2 <= mag_s1[0] | mag_s1[1] | mag_s1[2];
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;
		for (int c = 0; c < NCH; c++) begin
			nz_s3[c] <= |or_pad[c*8 +: 8];
			lbc_s3[c] <= dias_pkg::bitlen8(or_pad[c*8 +: 8]);
		end
		mag_s4 <= mag_s3;
		neg_s4 <= neg_s3;
		lb_s4 <= lb_c;
		// largest component lands in [2^29, 2^30)
		for (int i = 0; i < 3; i++) begin
			side_s5.r[i] <= 30'({mag_s4[i], 30'b0} >> lb_s4);
		end
		side_s5.neg <= neg_s4;
		side_s5.zero <= (lb_s4 == '0);
		for (int i = 0; i < 3; i++) begin
			sq_s6[i] <= 60'(side_s5.r[i]) * 60'(side_s5.r[i]);
		end
		side_s6 <= side_s5;
		sum_s7 <= 62'(sq_s6[0]) + 62'(sq_s6[1]) + 62'(sq_s6[2]);
		side_s7 <= side_s6;
		side_d[0] <= side_s7;
		for (int k = 1; k < SQL; k++) side_d[k] <= side_d[k-1];
		for (int i = 0; i < 3; i++) begin
			num_s8[i] <= {1'b0, side_d[SQL-1].r[i], 30'b0} + 61'(len_w >> 1);
		end
		len_s8 <= len_w;
		negf_s8 <= side_d[SQL-1].neg;
		zero_s8 <= side_d[SQL-1].zero;
	end

	dias_isqrt #(.IW(62)) u_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s7),
		.radicand (sum_s7),
		.out_valid(sq_vld),
		.root     (len_w)
	);

	// restoring divide, one quotient bit per stage, MSB first
	logic [2:0][60:0] rem_d [1:DIVN];
	logic [2:0][30:0] q_d [1:DIVN];
	logic [30:0]      len_d [1:DIVN];
	logic [2:0]       neg_d [1:DIVN];
	logic             zero_d [1:DIVN];
	logic             vld_d [1:DIVN];

	for (genvar j = 1; j <= DIVN; j++) begin : g_div
		localparam int K = DIVN - j;
		logic [2:0][60:0] rin;
		logic [2:0][30:0] qin;
		logic [30:0]      lin;
		logic [2:0]       nin;
		logic             zin, vin;
		logic [61:0]      dv;
		if (j == 1) begin : g_first
			assign rin = num_s8;
			assign qin = '0;
			assign lin = len_s8;
			assign nin = negf_s8;
			assign zin = zero_s8;
			assign vin = vld_s8;
		end else begin : g_next
			assign rin = rem_d[j-1];
			assign qin = q_d[j-1];
			assign lin = len_d[j-1];
			assign nin = neg_d[j-1];
			assign zin = zero_d[j-1];
			assign vin = vld_d[j-1];
		end
		assign dv = 62'(lin) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_d[j] <= 1'b0;
			else vld_d[j] <= vin;
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if ({1'b0, rin[i]} >= dv) begin
					rem_d[j][i] <= 61'({1'b0, rin[i]} - dv);
					q_d[j][i] <= qin[i] | (31'd1 << K);
				end else begin
					rem_d[j][i] <= rin[i];
					q_d[j][i] <= qin[i];
				end
			end
			len_d[j] <= lin;
			neg_d[j] <= nin;
			zero_d[j] <= zin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= vld_d[DIVN];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			unit[i] <= neg_d[DIVN][i] ? -$signed({1'b0, q_d[DIVN][i]})
				: $signed({1'b0, q_d[DIVN][i]});
		end
		zero <= zero_d[DIVN];
	end
endmodule

FILE: rtl/core/dihedral_angle_sine.sv
// Signed dihedral angle sine and arcsine of a hinge of two triangles.
// Throughput: one word per cycle; busy is never raised, the pipeline never stalls.
// Depth is set by three 31..32-step root units, the 31-step dividers and 30 CORDIC steps.
// Reset (arst_n low) clears all valid bits; data registers are not reset.
// Depends on dias_pkg, dias_unit, dias_isqrt.
module dihedral_angle_sine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] apex1_x,
	input  logic signed [31:0] apex1_y,
	input  logic signed [31:0] apex1_z,
	input  logic signed [31:0] apex2_x,
	input  logic signed [31:0] apex2_y,
	input  logic signed [31:0] apex2_z,
	input  logic signed [31:0] edge_start_x,
	input  logic signed [31:0] edge_start_y,
	input  logic signed [31:0] edge_start_z,
	input  logic signed [31:0] edge_end_x,
	input  logic signed [31:0] edge_end_y,
	input  logic signed [31:0] edge_end_z,
	output logic               done,
	output logic signed [31:0] sine_value,
	output logic signed [30:0] angle_value,
	output logic               degenerate
);
	localparam int NW = dias_pkg::NRM_W;
	localparam int EW = dias_pkg::EDG_W;
	localparam int NC = dias_pkg::CORDIC_STEPS;

	typedef struct packed {
		logic pos;
		logic neg;
		logic deg;
	} dot_side_t;

	typedef struct packed {
		logic signed [31:0] sine;
		logic [30:0]        mag;
		logic               deg;
	} asin_side_t;

	assign busy = 1'b0;

	// ---------------- front end: exact differences and cross products
	logic signed [31:0] p [4][3];
	assign p[0] = '{apex1_x, apex1_y, apex1_z};
	assign p[1] = '{apex2_x, apex2_y, apex2_z};
	assign p[2] = '{edge_start_x, edge_start_y, edge_start_z};
	assign p[3] = '{edge_end_x, edge_end_y, edge_end_z};

	logic vld_s1, vld_s2, vld_s3;
	logic signed [EW-1:0] e_s1 [3], a1_s1 [3], b1_s1 [3], a2_s1 [3], b2_s1 [3];
	logic signed [EW-1:0] e_s2 [3], e_s3 [3];
	logic signed [65:0]   pr1_s2 [6], pr2_s2 [6];
	logic signed [NW-1:0] n1_s3 [3], n2_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy; vld_s2 <= vld_s1; vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			e_s1[j]  <= EW'(p[3][j]) - EW'(p[2][j]);
			a1_s1[j] <= EW'(p[2][j]) - EW'(p[0][j]);
			b1_s1[j] <= EW'(p[3][j]) - EW'(p[0][j]);
			a2_s1[j] <= EW'(p[3][j]) - EW'(p[1][j]);
			b2_s1[j] <= EW'(p[2][j]) - EW'(p[1][j]);
		end
		// N = a x b, partial products paired per component
		for (int j = 0; j < 3; j++) begin
			pr1_s2[2*j]   <= a1_s1[(j+1)%3] * b1_s1[(j+2)%3];
			pr1_s2[2*j+1] <= a1_s1[(j+2)%3] * b1_s1[(j+1)%3];
			pr2_s2[2*j]   <= a2_s1[(j+1)%3] * b2_s1[(j+2)%3];
			pr2_s2[2*j+1] <= a2_s1[(j+2)%3] * b2_s1[(j+1)%3];
		end
		e_s2 <= e_s1;
		for (int j = 0; j < 3; j++) begin
			n1_s3[j] <= NW'(pr1_s2[2*j]) - NW'(pr1_s2[2*j+1]);
			n2_s3[j] <= NW'(pr2_s2[2*j]) - NW'(pr2_s2[2*j+1]);
		end
		e_s3 <= e_s2;
	end

	// ---------------- unit vectors
	logic signed [31:0] eu [3], n1u [3], n2u [3];
	logic               ze, z1, z2, vu, vu1, vu2;

	dias_unit #(.VW(EW)) u_edge (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3), .vec(e_s3),
		.out_valid(vu), .unit(eu), .zero(ze)
	);
	dias_unit #(.VW(NW)) u_nrm1 (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3), .vec(n1_s3),
		.out_valid(vu1), .unit(n1u), .zero(z1)
	);
	dias_unit #(.VW(NW)) u_nrm2 (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3), .vec(n2_s3),
		.out_valid(vu2), .unit(n2u), .zero(z2)
	);

	// ---------------- n1 x n2, rounding, length and edge dot sign
	logic vld_t1, vld_t2, vld_t3, vld_t4, vld_t5, vld_t6, vld_t7, vld_t8, vld_t9, vld_t10;
	logic signed [63:0] pp_t1 [3][2];
	logic signed [31:0] e_t1 [3], e_t2 [3], e_t3 [3], e_t4 [3];
	logic               deg_t1, deg_t2, deg_t3, deg_t4, deg_t5;
	logic signed [64:0] c_t2 [3];
	logic [64:0]        cmag_t3 [3];
	logic [2:0]         cneg_t3, cneg_t4;
	logic [31:0]        m_t4 [3];
	logic signed [32:0] cms [3];
	logic [63:0]        sq_t5 [3];
	logic signed [64:0] dp_t5 [3];
	logic [63:0]        sum_t6;
	logic signed [66:0] dot_c;
	dot_side_t          ds_t6;
	dot_side_t          ds_d [32];
	logic               lsq_vld;
	logic [31:0]        len_w;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cms[j] = cneg_t4[j] ? -$signed({1'b0, m_t4[j]}) : $signed({1'b0, m_t4[j]});
		end
		dot_c = 67'(dp_t5[0]) + 67'(dp_t5[1]) + 67'(dp_t5[2]);
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			pp_t1[j][0] <= n1u[(j+1)%3] * n2u[(j+2)%3];
			pp_t1[j][1] <= n1u[(j+2)%3] * n2u[(j+1)%3];
		end
		e_t1 <= eu;
		deg_t1 <= ze | z1 | z2;

		for (int j = 0; j < 3; j++) c_t2[j] <= 65'(pp_t1[j][0]) - 65'(pp_t1[j][1]);
		e_t2 <= e_t1;
		deg_t2 <= deg_t1;

		for (int j = 0; j < 3; j++) begin
			cneg_t3[j] <= c_t2[j][64];
			cmag_t3[j] <= c_t2[j][64] ? 65'(-c_t2[j]) : 65'(c_t2[j]);
		end
		e_t3 <= e_t2;
		deg_t3 <= deg_t2;

		// Q2.60 to Q1.30, half away from zero on the magnitude
		for (int j = 0; j < 3; j++) begin
			m_t4[j] <= 32'((66'(cmag_t3[j]) + (66'd1 << 29)) >> 30);
		end
		cneg_t4 <= cneg_t3;
		e_t4 <= e_t3;
		deg_t4 <= deg_t3;

		for (int j = 0; j < 3; j++) begin
			sq_t5[j] <= 64'(m_t4[j]) * 64'(m_t4[j]);
			dp_t5[j] <= cms[j] * e_t4[j];
		end
		deg_t5 <= deg_t4;

		sum_t6 <= sq_t5[0] + sq_t5[1] + sq_t5[2];
		ds_t6.pos <= !dot_c[66] && (dot_c != '0);
		ds_t6.neg <= dot_c[66];
		ds_t6.deg <= deg_t5;

		ds_d[0] <= ds_t6;
		for (int k = 1; k < 32; k++) ds_d[k] <= ds_d[k-1];
	end

	dias_isqrt #(.IW(64)) u_clen (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_t6), .radicand(sum_t6),
		.out_valid(lsq_vld), .root(len_w)
	);

	// ---------------- sine, then sqrt(1 - s^2) for the arcsine
	logic signed [31:0] sine_t7, sine_t8, sine_t9, sine_t10;
	logic               deg_t7, deg_t8, deg_t9, deg_t10;
	logic [31:0]        len_c;
	logic [30:0]        a_t8, a_t9, a_t10;
	logic [61:0]        asq_t9, rad_t10;
	asin_side_t         as_d [31];
	logic               xsq_vld;
	logic [30:0]        x_w;

	assign len_c = (len_w > dias_pkg::ONE_Q30) ? dias_pkg::ONE_Q30 : len_w;

	always_ff @(posedge clk) begin
		if (ds_d[31].deg || !(ds_d[31].pos || ds_d[31].neg)) sine_t7 <= '0;
		else if (ds_d[31].pos) sine_t7 <= $signed(len_c);
		else sine_t7 <= -$signed(len_c);
		deg_t7 <= ds_d[31].deg;

		a_t8 <= sine_t7[31] ? 31'(-sine_t7) : 31'(sine_t7);
		sine_t8 <= sine_t7;
		deg_t8 <= deg_t7;

		asq_t9 <= 62'(a_t8) * 62'(a_t8);
		a_t9 <= a_t8;
		sine_t9 <= sine_t8;
		deg_t9 <= deg_t8;

		rad_t10 <= (62'd1 << 60) - asq_t9;
		a_t10 <= a_t9;
		sine_t10 <= sine_t9;
		deg_t10 <= deg_t9;

		as_d[0] <= '{sine: sine_t10, mag: a_t10, deg: deg_t10};
		for (int k = 1; k < 31; k++) as_d[k] <= as_d[k-1];
	end

	dias_isqrt #(.IW(62)) u_cos (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_t10), .radicand(rad_t10),
		.out_valid(xsq_vld), .root(x_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_t1 <= 1'b0; vld_t2 <= 1'b0; vld_t3 <= 1'b0; vld_t4 <= 1'b0;
			vld_t5 <= 1'b0; vld_t6 <= 1'b0; vld_t7 <= 1'b0; vld_t8 <= 1'b0;
			vld_t9 <= 1'b0; vld_t10 <= 1'b0;
		end else begin
			vld_t1 <= vu & vu1 & vu2; vld_t2 <= vld_t1; vld_t3 <= vld_t2;
			vld_t4 <= vld_t3; vld_t5 <= vld_t4; vld_t6 <= vld_t5;
			vld_t7 <= lsq_vld; vld_t8 <= vld_t7; vld_t9 <= vld_t8; vld_t10 <= vld_t9;
		end
	end

	// ---------------- CORDIC vectoring: rotate (x, |s|) onto the x axis
	logic signed [33:0] cx [1:NC], cy [1:NC];
	logic signed [32:0] cz [1:NC];
	asin_side_t         cs [1:NC];
	logic               cv [1:NC];

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		localparam logic signed [32:0] ATAN = $signed(33'(dias_pkg::atan_q29(i)));
		logic signed [33:0] xin, yin;
		logic signed [32:0] zin;
		asin_side_t         sin_side;
		logic               vin;
		if (i == 0) begin : g_first
			assign xin = $signed(34'(x_w));
			assign yin = $signed(34'(as_d[30].mag));
			assign zin = '0;
			assign sin_side = as_d[30];
			assign vin = xsq_vld;
		end else begin : g_next
			assign xin = cx[i];
			assign yin = cy[i];
			assign zin = cz[i];
			assign sin_side = cs[i];
			assign vin = cv[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv[i+1] <= 1'b0;
			else cv[i+1] <= vin;
		end

		always_ff @(posedge clk) begin
			if (yin > 34'sd0) begin
				cx[i+1] <= xin + (yin >>> i);
				cy[i+1] <= yin - (xin >>> i);
				cz[i+1] <= zin + ATAN;
			end else begin
				cx[i+1] <= xin - (yin >>> i);
				cy[i+1] <= yin + (xin >>> i);
				cz[i+1] <= zin - ATAN;
			end
			cs[i+1] <= sin_side;
		end
	end

	// ---------------- clamp, sign and output register
	logic [30:0] zc;
	always_comb begin
		if (cz[NC][32]) zc = '0;
		else if (cz[NC] > $signed({2'b00, dias_pkg::ANGLE_MAX})) zc = dias_pkg::ANGLE_MAX;
		else zc = cz[NC][30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= cv[NC];
	end

	always_ff @(posedge clk) begin
		sine_value <= cs[NC].sine;
		degenerate <= cs[NC].deg;
		if (cs[NC].mag == '0) angle_value <= '0;
		else if (cs[NC].sine[31]) angle_value <= -$signed(zc);
		else angle_value <= $signed(zc);
	end
endmodule
